// ----- hw/rtl/int_to_decimal_ascii_assert.svh -----
// assertion macros used by the checker file
`ifndef INT_TO_DECIMAL_ASCII_ASSERT_SVH
`define INT_TO_DECIMAL_ASCII_ASSERT_SVH

// same-cycle implication, sampled on the rising clock edge
`define I2DA_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define I2DA_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ----- hw/rtl/i2da_pkg.sv -----
// ----------------------------------------------------------------------------
// i2da_pkg
// Shared constants and types of the integer to decimal text converter.
// ----------------------------------------------------------------------------
package i2da_pkg;

   localparam int ValueW    = 32;
   localparam int DigitW    = 4;
   localparam int CharW     = 6;
   localparam int NumDigits = 10;
   localparam int StepW     = $clog2(ValueW);
   localparam int LeftW     = $clog2(NumDigits + 1);

   localparam logic [CharW-1:0] CHAR_ZERO  = 6'd48;
   localparam logic [CharW-1:0] CHAR_MINUS = 6'd45;

   typedef struct packed {
      logic clear;
      logic dabble;
      logic advance;
   } i2da_cell_ctl_type;

endpackage

// ----- hw/rtl/i2da_bcd_cell.sv -----
// ----------------------------------------------------------------------------
// i2da_bcd_cell
// One decimal digit of the shift-and-add-3 chain; also shifts whole digits
// toward the top of the chain while the text is read out.
// ----------------------------------------------------------------------------
module i2da_bcd_cell
   import i2da_pkg::*;
(
   input  logic              clock,
   input  i2da_cell_ctl_type ctl,
   input  logic              bit_in,
   input  logic [DigitW-1:0] digit_in,
   output logic              bit_out,
   output logic [DigitW-1:0] digit_out
);

   logic [DigitW-1:0] digit_ff;
   logic [DigitW-1:0] digit_next_in;
   logic [DigitW-1:0] adj;

   // add 3 before the shift when the digit would reach ten
   assign adj     = (digit_ff >= 4'd5) ? digit_ff + 4'd3 : digit_ff;
   assign bit_out = adj[DigitW-1];

   always_comb begin
      digit_next_in = digit_ff;
      if (ctl.clear) begin
         digit_next_in = '0;
      end else if (ctl.dabble) begin
         digit_next_in = {adj[DigitW-2:0], bit_in};
      end else if (ctl.advance) begin
         digit_next_in = digit_in;
      end
   end

   always_ff @(posedge clock) begin
      digit_ff <= digit_next_in;
   end

   assign digit_out = digit_ff;

endmodule

// ----- hw/rtl/int_to_decimal_ascii.sv -----
// ----------------------------------------------------------------------------
// int_to_decimal_ascii
// Signed 32-bit integer to decimal ASCII text, most significant first.
//
// A request on req_value is taken when req_valid is high and req_stall low.
// The magnitude is shifted through a chain of ten BCD digit cells, one bit
// per cycle. The digit chain then shifts one digit per cycle toward the
// output while the output register is free (leading zeros shift on without
// waiting), after a minus sign for a negative value. Once the last
// character enters the output register the block returns to idle; only
// then is the next request taken.
// Each character leaves on rsp_ascii_char with rsp_last marking the final
// one; leading zeros are dropped and zero gives a single '0'.
// rsp_stall holds the output register and pauses readout; the chain keeps
// its digits until the register frees up.
// A synchronous reset returns the block to idle and drops any pending
// character.
// ----------------------------------------------------------------------------
module int_to_decimal_ascii
   import i2da_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic signed [ValueW-1:0] req_value,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [CharW-1:0]        rsp_ascii_char,
   output logic                    rsp_last
);

   typedef enum logic [1:0] {
      IDLE,
      CONV,
      EMIT
   } state_type;

   state_type          state_ff;
   logic [ValueW-1:0]  mag_ff;
   logic [StepW-1:0]   step_ff;
   logic [LeftW-1:0]   left_ff;
   logic               neg_ff;
   logic               started_ff;
   logic               rsp_valid_ff;
   logic [CharW-1:0]   rsp_char_ff;
   logic               rsp_last_ff;

   logic [ValueW-1:0]  raw;
   logic               req_take;
   logic               out_free;
   logic               load_char;
   logic [DigitW-1:0]  top_digit;
   logic               top_last;
   logic               top_show;
   i2da_cell_ctl_type  ctl;

   logic               cell_bit   [NumDigits];
   logic [DigitW-1:0]  cell_digit [NumDigits];

   assign raw       = req_value;
   assign req_stall = (state_ff != IDLE);
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign top_digit = cell_digit[NumDigits-1];
   assign top_last  = (left_ff == LeftW'(1));
   assign top_show  = started_ff || (top_digit != '0) || top_last;

   always_comb begin
      ctl.clear   = req_take;
      ctl.dabble  = (state_ff == CONV);
      ctl.advance = (state_ff == EMIT) && !neg_ff && (out_free || !top_show);
   end

   assign load_char = (state_ff == EMIT) && (neg_ff ? out_free : (ctl.advance && top_show));

   for (genvar i = 0; i < NumDigits; i++) begin : g_cell
      logic              b_in;
      logic [DigitW-1:0] d_in;
      if (i == 0) begin : g_head
         assign b_in = mag_ff[ValueW-1];
         assign d_in = '0;
      end else begin : g_link
         assign b_in = cell_bit[i-1];
         assign d_in = cell_digit[i-1];
      end
      i2da_bcd_cell u_cell (
         .clock     (clock),
         .ctl       (ctl),
         .bit_in    (b_in),
         .digit_in  (d_in),
         .bit_out   (cell_bit[i]),
         .digit_out (cell_digit[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         rsp_valid_ff <= 1'b0;
         step_ff      <= '0;
         left_ff      <= '0;
         neg_ff       <= 1'b0;
         started_ff   <= 1'b0;
      end else begin
         if (load_char) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            IDLE: begin
               if (req_take) begin
                  mag_ff     <= raw[ValueW-1] ? (~raw + ValueW'(1)) : raw;
                  neg_ff     <= raw[ValueW-1];
                  step_ff    <= '0;
                  left_ff    <= LeftW'(NumDigits);
                  started_ff <= 1'b0;
                  state_ff   <= CONV;
               end
            end
            CONV: begin
               mag_ff  <= {mag_ff[ValueW-2:0], 1'b0};
               step_ff <= step_ff + StepW'(1);
               if (step_ff == StepW'(ValueW - 1)) begin
                  state_ff <= EMIT;
               end
            end
            EMIT: begin
               if (neg_ff) begin
                  if (out_free) begin
                     rsp_char_ff  <= CHAR_MINUS;
                     rsp_last_ff  <= 1'b0;
                     neg_ff       <= 1'b0;
                  end
               end else if (ctl.advance) begin
                  left_ff <= left_ff - LeftW'(1);
                  if (top_show) begin
                     rsp_char_ff  <= CHAR_ZERO + CharW'(top_digit);
                     rsp_last_ff  <= top_last;
                     started_ff   <= 1'b1;
                  end
                  if (top_last) begin
                     state_ff <= IDLE;
                  end
               end
            end
            default: begin
               state_ff <= IDLE;
            end
         endcase
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_ascii_char = rsp_char_ff;
   assign rsp_last       = rsp_last_ff;

endmodule

// ----- hw/rtl/i2da_checker.sv -----
// ----------------------------------------------------------------------------
// i2da_checker
// Port-level checks of the integer to decimal text converter.
// ----------------------------------------------------------------------------
`include "int_to_decimal_ascii_assert.svh"

module i2da_checker
   import i2da_pkg::*;
(
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_stall,
   input logic                     rsp_valid,
   input logic                     rsp_stall,
   input logic [CharW-1:0]         rsp_ascii_char,
   input logic                     rsp_last
);

   logic             is_digit;
   logic             is_minus;
   logic             rsp_wait;
   logic [CharW:0]   rsp_data;

   assign is_digit = (rsp_ascii_char >= CHAR_ZERO) && (rsp_ascii_char <= CHAR_ZERO + 6'd9);
   assign is_minus = (rsp_ascii_char == CHAR_MINUS);
   assign rsp_wait = rsp_valid && rsp_stall;
   assign rsp_data = {rsp_ascii_char, rsp_last};

   // stalled response holds
   `I2DA_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_wait, rsp_valid && $stable(rsp_data))
   // only digits or a minus sign leave
   `I2DA_ASSERT_IMP(a_char_range, clock, reset, rsp_valid, is_digit || is_minus)
   // a minus sign is never the final character
   `I2DA_ASSERT_IMP(a_minus_not_last, clock, reset, rsp_valid && is_minus, !rsp_last)
   // one request at a time
   `I2DA_ASSERT_NXT(a_busy_after_take, clock, reset, req_valid && !req_stall, req_stall)

endmodule

bind int_to_decimal_ascii i2da_checker u_i2da_checker (.*);

// ----- tb/sv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the integer to decimal text converter.
//
// Signed values go in one request at a time. A class predicts the character
// string for each accepted request and compares every character that comes
// out, in order, against it. Both sides idle in short random bursts. The
// run starts with corner values: zero, one-digit and ten-digit numbers, and
// both ends of the signed range. Random values follow, spread over every
// digit count, and the last stretch runs with no idling at all.
// ----------------------------------------------------------------------------
module tb_top
   import i2da_pkg::*;
;

   localparam int Radix       = 10;
   localparam int RandomItems = 248;
   localparam int DrainCycles = 60;
   localparam int StallLimit  = 2000;
   localparam int ErrorPrints = 40;

   class decimal_text_checker;
      typedef struct packed {
         logic [CharW-1:0] ch;
         logic             last;
      } text_char_type;

      text_char_type text_chars[$];
      int            errors = 0;

      function void note_error();
         errors++;
      endfunction

      // expected characters of one accepted request, most significant first
      function void take_value(input logic signed [ValueW-1:0] value);
         logic [ValueW-1:0] mag;
         logic [DigitW-1:0] digit [NumDigits];
         text_char_type     entry;
         int                ndig;
         mag  = value;
         ndig = 0;
         if (value[ValueW-1]) begin
            mag = ~mag + 1'b1;
         end
         if (mag == 0) begin
            entry.ch   = CHAR_ZERO;
            entry.last = 1'b1;
            text_chars.push_back(entry);
         end else begin
            while (mag != 0) begin
               digit[ndig] = DigitW'(mag % Radix);
               mag         = mag / Radix;
               ndig++;
            end
            if (value[ValueW-1]) begin
               entry.ch   = CHAR_MINUS;
               entry.last = 1'b0;
               text_chars.push_back(entry);
            end
            for (int i = ndig - 1; i >= 0; i--) begin
               entry.ch   = CHAR_ZERO + CharW'(digit[i]);
               entry.last = (i == 0);
               text_chars.push_back(entry);
            end
         end
      endfunction

      function void check_char(input logic [CharW-1:0] ch, input logic last);
         text_char_type want;
         if (text_chars.size() == 0) begin
            if (errors < ErrorPrints) begin
               $display("%0t: unexpected character: expected none, actual %0d last %0b",
                        $time, ch, last);
            end
            note_error();
         end else begin
            want = text_chars.pop_front();
            if (ch !== want.ch) begin
               if (errors < ErrorPrints) begin
                  $display("%0t: ascii_char mismatch: expected %0d, actual %0d",
                           $time, want.ch, ch);
               end
               note_error();
            end
            if (last !== want.last) begin
               if (errors < ErrorPrints) begin
                  $display("%0t: last mismatch: expected %0b, actual %0b",
                           $time, want.last, last);
               end
               note_error();
            end
         end
      endfunction
   endclass

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic signed [ValueW-1:0] req_value = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic [CharW-1:0]         rsp_ascii_char;
   logic                     rsp_last;

   decimal_text_checker text_check = new();
   int                  idle_pct = 30;
   int                  stall_left = 0;
   int                  quiet_cycles = 0;

   int_to_decimal_ascii dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_ascii_char(rsp_ascii_char),
      .rsp_last      (rsp_last)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // spread over digit counts, with some full-range values
   function automatic logic signed [ValueW-1:0] random_value();
      int unsigned       ndig;
      longint            lo;
      longint            hi;
      logic [ValueW-1:0] mag;
      if ($urandom_range(0, 4) == 0) begin
         return $urandom;
      end
      ndig = $urandom_range(1, NumDigits);
      hi   = 1;
      repeat (ndig) hi = hi * Radix;
      lo   = (ndig == 1) ? 0 : hi / Radix;
      hi   = hi - 1;
      if (hi > 64'sd2147483647) begin
         hi = 64'sd2147483647;
      end
      mag = $urandom_range(32'(hi), 32'(lo));
      if ($urandom_range(0, 1) == 1) begin
         mag = -mag;
      end
      return mag;
   endfunction

   task automatic send_value(input logic signed [ValueW-1:0] value);
      int gap;
      gap = 0;
      if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
         gap = $urandom_range(1, 4);
      end
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_value <= value;
      do @(posedge clock); while (req_stall);
      text_check.take_value(value);
   endtask

   // output side: check accepted characters, stall in short bursts
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         text_check.check_char(rsp_ascii_char, rsp_last);
      end
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall  <= 1'b1;
      end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
         stall_left <= $urandom_range(0, 3);
         rsp_stall  <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // watchdog on cycles with no request and no character taken
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= StallLimit) begin
         $display("int_to_decimal_ascii regression: fail");
         $finish;
      end
   end

   initial begin
      logic signed [ValueW-1:0] corner_values [$];
      corner_values = '{
         32'sd0, 32'sd1, -32'sd1, 32'sd9, 32'sd10, -32'sd10, 32'sd99, -32'sd100,
         32'sd2147483647, -32'sd2147483647, 32'h8000_0000, 32'sd1000000000,
         32'sd999999999, -32'sd999999999, 32'sd1234567890, -32'sd1234567890,
         32'sd5, -32'sd5, 32'h5555_5555, 32'hAAAA_AAAA, 32'sd4294, -32'sd70000
      };
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      foreach (corner_values[i]) begin
         send_value(corner_values[i]);
      end
      for (int n = 0; n < RandomItems; n++) begin
         if (n % 40 == 0) begin
            if (n >= RandomItems - 50) begin
               idle_pct <= 0;
            end else begin
               case ($urandom_range(0, 3))
                  0: idle_pct <= 0;
                  1: idle_pct <= 15;
                  2: idle_pct <= 35;
                  default: idle_pct <= 60;
               endcase
            end
         end
         send_value(random_value());
      end
      req_valid <= 1'b0;
      while (text_check.text_chars.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (text_check.errors == 0 && text_check.text_chars.size() == 0) begin
         $display("int_to_decimal_ascii regression: pass");
      end else begin
         $display("int_to_decimal_ascii regression: fail");
      end
      $finish;
   end

endmodule
